FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. They use the clk and arst_n of the
// module that expands them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// Shared sizes and types of the preemptive priority scheduler.
// ---------------------------------------------------------------------------
package pps_pkg;

	localparam int MAX_JOBS = 64;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int TIME_W   = 32;
	localparam int SLOT_W   = 6;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// one job table entry
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
		logic [15:0] left;
	} job_t;

	// control from the sequencer to the pick unit
	typedef struct packed {
		logic             clear;
		logic             vld;
		logic [IDX_W-1:0] idx;
	} pick_ctl_t;

endpackage

FILE: rtl/core/pps_job_table.sv
// ---------------------------------------------------------------------------
// pps_job_table
// Job table memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pps_job_table (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [pps_pkg::IDX_W-1:0] wr_addr,
	input  pps_pkg::job_t           wr_data,
	input  logic                    rd_en,
	input  logic [pps_pkg::IDX_W-1:0] rd_addr,
	output pps_pkg::job_t           rd_data
);

	pps_pkg::job_t mem [pps_pkg::MAX_JOBS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/pps_pick.sv
// ---------------------------------------------------------------------------
// pps_pick
// Running winner of a table scan: lowest prio, then earliest arrival,
// then lowest slot (entries arrive in slot order).
// ---------------------------------------------------------------------------
module pps_pick (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pps_pkg::pick_ctl_t        ctl,
	input  pps_pkg::job_t             rd_data,
	input  logic [pps_pkg::TIME_W-1:0] now,
	output logic                      found,
	output pps_pkg::job_t             best,
	output logic [pps_pkg::IDX_W-1:0] best_slot
);

	logic          found_q;
	pps_pkg::job_t best_q;
	logic [pps_pkg::IDX_W-1:0] slot_q;
	logic          elig;
	logic          better;

	// candidate must have arrived and have work left
	assign elig = ({16'd0, rd_data.arrival} <= now) && (rd_data.left != 16'd0);

	assign better = !found_q || (rd_data.prio < best_q.prio) ||
		((rd_data.prio == best_q.prio) && (rd_data.arrival < best_q.arrival));

	// found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.vld && elig) begin
			found_q <= 1'b1;
		end
	end

	// winner payload
	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.vld && elig && better) begin
			best_q <= rd_data;
			slot_q <= ctl.idx;
		end
	end

	assign found     = found_q;
	assign best      = best_q;
	assign best_slot = slot_q;

endmodule

FILE: rtl/core/preemptive_priority_scheduler.sv
// A load request gives no result; busy stays low.
// A tick request scans the loaded jobs, reading one table entry per cycle through
// the single read port, then writes back the picked job and forms the result.
// The result strobe lasts one cycle; a new request may be taken in that cycle.
// Reset (arst_n low) empties the table and zeroes the clock; entries are not cleared.
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler
// Job table with a sequential scan for the next job to run on each tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	input  logic [7:0]  prio,
	output logic        valid,
	output logic [5:0]  slot,
	output logic        idle,
	output logic        finished,
	output logic [31:0] end_time,
	output logic [31:0] wait_time,
	output logic [31:0] turnaround,
	output logic        all_done
);

	localparam int IDX_W  = pps_pkg::IDX_W;
	localparam int CNT_W  = pps_pkg::CNT_W;
	localparam int TIME_W = pps_pkg::TIME_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_CALC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0]  job_cnt_q;
	logic [CNT_W-1:0]  done_cnt_q;
	logic [TIME_W-1:0] clock_q;
	logic [CNT_W-1:0]  iss_q;

	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              accept;
	logic              load_ok;
	logic              tick_go;
	logic              has_jobs;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_last;
	pps_pkg::job_t     rd_data;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	pps_pkg::job_t     wr_data;

	pps_pkg::pick_ctl_t pick_ctl;
	logic              found;
	pps_pkg::job_t     best;
	logic [IDX_W-1:0]  best_slot;

	logic              fin_c;
	logic              fin_q;
	logic [TIME_W-1:0] end_q;
	logic [TIME_W-1:0] turn_q;

	logic              valid_q;
	logic [5:0]        slot_q;
	logic              idle_q;
	logic              finished_q;
	logic [31:0]       end_time_q;
	logic [31:0]       wait_time_q;
	logic [31:0]       turn_time_q;
	logic              all_done_q;

	// request decode
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign has_jobs = (job_cnt_q != '0);
	assign tick_go  = accept && (kind == pps_pkg::KIND_TICK);
	assign load_ok  = accept && (kind == pps_pkg::KIND_LOAD) &&
		(job_cnt_q < CNT_W'(pps_pkg::MAX_JOBS)) && (burst != 16'd0);

	// scan read issue
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_IDLE) begin
			rd_en = tick_go && has_jobs;
		end else if (state_q == ST_SCAN) begin
			rd_en   = (iss_q < job_cnt_q);
			rd_addr = iss_q[IDX_W-1:0];
		end
	end

	assign rd_last = (CNT_W'(rd_addr) == (job_cnt_q - CNT_W'(1)));

	// table write: new job on load, decremented work on tick
	assign fin_c = found && (best.left == 16'd1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = IDX_W'(job_cnt_q);
		wr_data = '{arrival: arrival, burst: burst, prio: prio, left: burst};
		if (state_q == ST_CALC) begin
			wr_en        = found;
			wr_addr      = best_slot;
			wr_data      = best;
			wr_data.left = best.left - 16'd1;
		end else begin
			wr_en = load_ok;
		end
	end

	pps_job_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign pick_ctl.clear = tick_go;
	assign pick_ctl.vld   = (state_q == ST_SCAN) && rd_vld_s1;
	assign pick_ctl.idx   = rd_idx_s1;

	pps_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.rd_data   (rd_data),
		.now       (clock_q),
		.found     (found),
		.best      (best),
		.best_slot (best_slot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = has_jobs ? ST_SCAN : ST_CALC;
				end
			end
			ST_SCAN: begin
				if (rd_vld_s1 && rd_last_s1) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: state_d = ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_cnt_q  <= '0;
			done_cnt_q <= '0;
			clock_q    <= '0;
			iss_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= rd_en;
			rd_last_s1 <= rd_en && rd_last;
			valid_q    <= (state_q == ST_EMIT);
			if (load_ok) begin
				job_cnt_q <= job_cnt_q + CNT_W'(1);
			end
			if (tick_go) begin
				iss_q <= CNT_W'(1);
			end else if ((state_q == ST_SCAN) && rd_en) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if ((state_q == ST_CALC) && fin_c) begin
				done_cnt_q <= done_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_EMIT) begin
				clock_q <= clock_q + TIME_W'(1);
			end
		end
	end

	// read index pipeline
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	// completion times
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			fin_q  <= fin_c;
			end_q  <= clock_q + TIME_W'(1);
			turn_q <= clock_q + TIME_W'(1) - TIME_W'(best.arrival);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			slot_q      <= found ? 6'(best_slot) : 6'd0;
			idle_q      <= !found;
			finished_q  <= fin_q;
			end_time_q  <= fin_q ? end_q : 32'd0;
			turn_time_q <= fin_q ? turn_q : 32'd0;
			wait_time_q <= fin_q ? (turn_q - TIME_W'(best.burst)) : 32'd0;
			all_done_q  <= (done_cnt_q == job_cnt_q);
		end
	end

	assign valid      = valid_q;
	assign slot       = slot_q;
	assign idle       = idle_q;
	assign finished   = finished_q;
	assign end_time   = end_time_q;
	assign wait_time  = wait_time_q;
	assign turnaround = turn_time_q;
	assign all_done   = all_done_q;

	// checks
	`ASSERT_NEXT(a_strobe_single, valid_q, !valid_q, "result strobe longer than one cycle")
	`ASSERT_IMP(a_fin_not_idle, valid_q && finished_q, !idle_q, "finished job on idle tick")
	`ASSERT_ALWAYS(a_done_le_jobs, done_cnt_q <= job_cnt_q, "more jobs done than loaded")
	`ASSERT_IMP(a_slot_loaded, found, CNT_W'(best_slot) < job_cnt_q, "picked slot not loaded")

endmodule

FILE: tb/sv/pps_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_checker
// Watches the request and result ports of the scheduler and keeps its own
// job table. Each accepted tick request yields one expected result. Each
// result strobe is checked field by field against the oldest expectation.
// ---------------------------------------------------------------------------
module pps_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        kind,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	input  logic [7:0]  prio,
	input  logic        valid,
	input  logic [5:0]  slot,
	input  logic        idle,
	input  logic        finished,
	input  logic [31:0] end_time,
	input  logic [31:0] wait_time,
	input  logic [31:0] turnaround,
	input  logic        all_done,
	output int          fail_count,
	output int          pending
);

	// one tick outcome, laid out in port order
	typedef struct packed {
		logic [5:0]  slot;
		logic        idle;
		logic        finished;
		logic [31:0] end_time;
		logic [31:0] wait_time;
		logic [31:0] turnaround;
		logic        all_done;
	} tick_result_t;

	// shadow job table
	logic [15:0]  tbl_arrival [pps_pkg::MAX_JOBS];
	logic [15:0]  tbl_burst   [pps_pkg::MAX_JOBS];
	logic [7:0]   tbl_prio    [pps_pkg::MAX_JOBS];
	logic [15:0]  tbl_left    [pps_pkg::MAX_JOBS];
	int unsigned  jobs_loaded;
	int unsigned  jobs_done;
	logic [31:0]  now_ticks;

	tick_result_t expected_ticks [$];
	tick_result_t want;
	tick_result_t got;
	string        bad_fields;
	int           mismatches;

	assign fail_count = mismatches;

	// pick the job to run, charge one unit of work, advance the clock
	function automatic tick_result_t run_tick();
		tick_result_t r;
		int           winner;
		bit           any;
		logic [31:0]  fin_at;
		logic [31:0]  turn;
		r      = '0;
		winner = 0;
		any    = 1'b0;
		for (int i = 0; i < jobs_loaded; i++) begin
			if ({16'd0, tbl_arrival[i]} <= now_ticks && tbl_left[i] != 16'd0) begin
				if (!any) begin
					winner = i;
					any    = 1'b1;
				end else if (tbl_prio[i] < tbl_prio[winner]) begin
					winner = i;
				end else if (tbl_prio[i] == tbl_prio[winner] &&
				             tbl_arrival[i] < tbl_arrival[winner]) begin
					winner = i;
				end
			end
		end
		if (any) begin
			tbl_left[winner] = tbl_left[winner] - 16'd1;
			r.slot = winner[5:0];
			if (tbl_left[winner] == 16'd0) begin
				fin_at       = now_ticks + 32'd1;
				turn         = fin_at - {16'd0, tbl_arrival[winner]};
				r.finished   = 1'b1;
				r.end_time   = fin_at;
				r.turnaround = turn;
				r.wait_time  = turn - {16'd0, tbl_burst[winner]};
				jobs_done++;
			end
		end
		r.idle     = !any;
		r.all_done = (jobs_done == jobs_loaded);
		now_ticks  = now_ticks + 32'd1;
		return r;
	endfunction

	// check results first, then take the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_loaded = 0;
			jobs_done   = 0;
			now_ticks   = '0;
			mismatches  = 0;
			expected_ticks.delete();
			pending <= 0;
		end else begin
			if (valid) begin
				got = {slot, idle, finished, end_time, wait_time, turnaround, all_done};
				if (expected_ticks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result strobe with no tick outstanding: %s%0d idle=%0b",
						         $realtime, "slot=", got.slot, got.idle);
				end else begin
					want       = expected_ticks.pop_front();
					bad_fields = "";
					if (got.slot != want.slot)             bad_fields = {bad_fields, " slot"};
					if (got.idle != want.idle)             bad_fields = {bad_fields, " idle"};
					if (got.finished != want.finished)     bad_fields = {bad_fields, " finished"};
					if (got.end_time != want.end_time)     bad_fields = {bad_fields, " end_time"};
					if (got.wait_time != want.wait_time)   bad_fields = {bad_fields, " wait_time"};
					if (got.turnaround != want.turnaround) bad_fields = {bad_fields, " turnaround"};
					if (got.all_done != want.all_done)     bad_fields = {bad_fields, " all_done"};
					if (bad_fields != "") begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: tick result mismatch in%s", $realtime, bad_fields);
							$display({"  expected slot=%0d idle=%0b fin=%0b",
							          " end=%0d wait=%0d turn=%0d done=%0b"},
							         want.slot, want.idle, want.finished, want.end_time,
							         want.wait_time, want.turnaround, want.all_done);
							$display({"  actual   slot=%0d idle=%0b fin=%0b",
							          " end=%0d wait=%0d turn=%0d done=%0b"},
							         got.slot, got.idle, got.finished, got.end_time,
							         got.wait_time, got.turnaround, got.all_done);
						end
					end
				end
			end
			if (start && !busy) begin
				if (kind == pps_pkg::KIND_LOAD) begin
					// full table and zero work are dropped
					if (jobs_loaded < pps_pkg::MAX_JOBS && burst != 16'd0) begin
						tbl_arrival[jobs_loaded] = arrival;
						tbl_burst[jobs_loaded]   = burst;
						tbl_prio[jobs_loaded]    = prio;
						tbl_left[jobs_loaded]    = burst;
						jobs_loaded++;
					end
				end else begin
					expected_ticks.push_back(run_tick());
				end
			end
			pending <= expected_ticks.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives load and tick requests into the scheduler with random gaps: a short
// directed run over ties, preemption, dropped loads and idle ticks, then a
// long random mix that fills the table. The checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS = 1900;
	localparam int DRAIN_CYCLES = 2 * (pps_pkg::MAX_JOBS + 3);
	localparam int STALL_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = pps_pkg::KIND_LOAD;
	logic [15:0] arrival = '0;
	logic [15:0] burst = '0;
	logic [7:0]  prio = '0;
	logic        busy;
	logic        valid;
	logic [5:0]  slot;
	logic        idle;
	logic        finished;
	logic [31:0] end_time;
	logic [31:0] wait_time;
	logic [31:0] turnaround;
	logic        all_done;
	int          fail_count;
	int          pending;

	int unsigned ticks_sent = 0;
	int unsigned jobs_sent = 0;
	int unsigned stall_cycles = 0;
	bit          steady = 1'b0;

	preemptive_priority_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.arrival   (arrival),
		.burst     (burst),
		.prio      (prio),
		.valid     (valid),
		.slot      (slot),
		.idle      (idle),
		.finished  (finished),
		.end_time  (end_time),
		.wait_time (wait_time),
		.turnaround(turnaround),
		.all_done  (all_done)
	);

	pps_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.arrival   (arrival),
		.burst     (burst),
		.prio      (prio),
		.valid     (valid),
		.slot      (slot),
		.idle      (idle),
		.finished  (finished),
		.end_time  (end_time),
		.wait_time (wait_time),
		.turnaround(turnaround),
		.all_done  (all_done),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// one request: optional gap, then hold start until accepted
	task automatic issue(input logic k, input logic [15:0] a, input logic [15:0] b,
	                     input logic [7:0] p);
		int gap;
		gap = steady ? 0 : int'($urandom_range(0, 8));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		kind    <= k;
		arrival <= a;
		burst   <= b;
		prio    <= p;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (k == pps_pkg::KIND_TICK)
			ticks_sent++;
		else if (b != 16'd0 && jobs_sent < pps_pkg::MAX_JOBS)
			jobs_sent++;
	endtask

	task automatic tick();
		issue(pps_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// stop sending until every outstanding tick has reported
	task automatic wait_quiet();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// stall watchdog: cycles with neither an accepted request nor a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || valid) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned items;
		int unsigned roll;
		logic [15:0] a;
		logic [15:0] b;
		logic [7:0]  p;
		bit          drained;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: idle ticks with everything done, zero-work load dropped
		tick();
		issue(pps_pkg::KIND_LOAD, 16'd5, 16'd0, 8'd3);
		tick();
		// clock is 2 now; ties on priority, arrival and slot, plus a late preemptor
		issue(pps_pkg::KIND_LOAD, 16'd0, 16'd1, 8'd0);
		issue(pps_pkg::KIND_LOAD, 16'd0, 16'd3, 8'd255);
		issue(pps_pkg::KIND_LOAD, 16'd2, 16'd2, 8'd7);
		issue(pps_pkg::KIND_LOAD, 16'd1, 16'd2, 8'd7);
		issue(pps_pkg::KIND_LOAD, 16'd1, 16'd1, 8'd7);
		issue(pps_pkg::KIND_LOAD, 16'd9, 16'd1, 8'd1);
		repeat (11) tick();
		// jobs that never arrive: one with all fields at their top values
		issue(pps_pkg::KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
		issue(pps_pkg::KIND_LOAD, 16'h8000, 16'h8000, 8'h80);
		tick();

		// random mix: mostly ticks; loads mostly near the current time with small work
		items   = 0;
		drained = 1'b0;
		while (items < RANDOM_ITEMS) begin
			if (items % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (!drained && items >= RANDOM_ITEMS / 2) begin
				wait_quiet();
				drained = 1'b1;
			end
			roll = $urandom_range(0, 39);
			if ((jobs_sent < pps_pkg::MAX_JOBS && roll < 2) || roll == 0) begin
				if ($urandom_range(0, 9) == 0) begin
					a = 16'($urandom_range(32768, 65535));
					b = 16'($urandom_range(1, 65535));
					p = 8'($urandom_range(0, 255));
				end else begin
					a = 16'(ticks_sent + $urandom_range(0, 40));
					b = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
					p = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
					                         : 8'($urandom_range(0, 255));
				end
				// dropped loads do not count toward the item total
				if (b != 16'd0 && jobs_sent < pps_pkg::MAX_JOBS)
					items++;
				issue(pps_pkg::KIND_LOAD, a, b, p);
			end else begin
				tick();
				items++;
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
